[rtl/target_frame_receiver_defines.svh]
// Assertion macros used by the target frame receiver controller.
// No dependencies.
`ifndef TARGET_FRAME_RECEIVER_DEFINES_SVH
`define TARGET_FRAME_RECEIVER_DEFINES_SVH
`define TFR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/tfr_pkg.sv]
// Types and constants of the target frame receiver.
// No dependencies.
package tfr_pkg;
    localparam logic [7:0]  SYNC_A = 8'hA5;
    localparam logic [7:0]  SYNC_B = 8'h5A;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [3:0]  HDR_LEN = 4'd8;
    localparam logic [4:0]  TGT_LEN = 5'd25;
    localparam logic [7:0]  PROTO_VERSION = 8'd1;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;

    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_OTHER = 3'd1;
    localparam logic [2:0] ST_TARGET = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_CODE = 1'b1;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [7:0]  data_byte;
        logic [31:0] elapsed_ms;
    } tfr_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        target_valid;
        logic        tracking;
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_rate_bits;
        logic [31:0] pitch_rate_bits;
        logic [31:0] confidence_bits;
        logic [31:0] stamp_ms;
        logic [31:0] updates;
    } tfr_out_t;

    typedef enum logic [2:0] {
        S_IDLE, S_BYTE, S_SCAN, S_HCRC, S_CHECK, S_TICK, S_OUT
    } tfr_state_t;

    typedef struct packed {
        logic load;
        logic do_byte;
        logic scan;
        logic hcrc;
        logic check;
        logic tick;
        logic emit;
    } tfr_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hcrc_done;
        logic need_check;
        logic need_hcrc;
    } tfr_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage

[rtl/target_frame_receiver.sv]
// Top level of the target frame receiver.
// Depends on tfr_pkg, tfr_ctrl and tfr_datapath.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_item (tfr_in_t)
//   m_        out        m_valid / m_ready    m_item (tfr_out_t)
//   cfg_      in         cfg_we               cfg_index, cfg_data
//
// A tick goes through S_IDLE, S_TICK and S_OUT, a byte through S_IDLE, S_BYTE,
// S_SCAN (a one-byte-a-cycle sync rescan of up to eight header bytes), S_HCRC
// (header CRC) or S_CHECK as needed, and S_OUT. One item is in flight.
// Reset is synchronous and clears all control and target state.
// A stalled result holds in the datapath registers until m_ready.
module target_frame_receiver
    import tfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tfr_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output tfr_out_t    m_item,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    tfr_cmd_t  cmd;
    tfr_stat_t stat;

    tfr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid),
        .in_tick(s_item.opcode == OP_TICK), .out_ready(m_ready), .stat(stat),
        .in_ready(s_ready), .out_valid(m_valid), .cmd(cmd)
    );

    tfr_datapath #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_item(s_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .stat(stat), .out_item(m_item)
    );
endmodule

[rtl/tfr_ctrl.sv]
// Controller state machine of the target frame receiver.
// Depends on tfr_pkg and the assertion macro header.
`include "target_frame_receiver_defines.svh"
module tfr_ctrl
    import tfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_tick,
    input  logic      out_ready,
    input  tfr_stat_t stat,
    output logic      in_ready,
    output logic      out_valid,
    output tfr_cmd_t  cmd
);
    tfr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = in_tick ? S_TICK : S_BYTE;
                end
            end
            S_BYTE: state_next = S_SCAN;
            S_SCAN: begin
                if (stat.scan_done) begin
                    if (stat.need_hcrc) begin
                        state_next = S_HCRC;
                    end else if (stat.need_check) begin
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_HCRC: if (stat.hcrc_done) state_next = S_OUT;
            S_CHECK: state_next = S_OUT;
            S_TICK: state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_BYTE: cmd.do_byte = 1'b1;
            S_SCAN: cmd.scan = 1'b1;
            S_HCRC: cmd.hcrc = 1'b1;
            S_CHECK: cmd.check = 1'b1;
            S_TICK: cmd.tick = 1'b1;
            S_OUT: begin
                out_valid = 1'b1;
                cmd.emit = 1'b1;
            end
            default: ;
        endcase
    end

    `TFR_ASSERT_IMPL(a_ready_idle, aclk, aresetn, in_ready, !out_valid, "ready while result pending")
    `TFR_ASSERT_NEXT(a_load_leaves, aclk, aresetn, in_valid && in_ready, state_reg != S_IDLE,
        "accepted item did not start")
    `TFR_ASSERT_NEXT(a_out_holds, aclk, aresetn, out_valid && !out_ready, out_valid,
        "result dropped")
endmodule

[rtl/tfr_datapath.sv]
// Datapath of the target frame receiver: header window, CRC, capture and target state.
// Depends on tfr_pkg.
module tfr_datapath
    import tfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  tfr_cmd_t    cmd,
    input  tfr_in_t     in_item,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output tfr_stat_t   stat,
    output tfr_out_t    out_item
);
    logic [7:0]  win_reg [8];
    logic [15:0] held_reg;
    logic [15:0] crc_reg;
    logic [7:0]  crc_low_reg;
    logic [7:0]  cap_reg [25];
    logic [31:0] fld_reg [6];
    logic        valid_reg, track_reg;
    logic [31:0] upd_reg, age_reg, tmo_reg;
    logic [7:0]  code_reg;
    logic [7:0]  byte_reg;
    logic [31:0] ela_reg;
    logic [2:0]  st_reg;
    logic        chk_reg;
    logic        hcrc_need_reg;
    logic [2:0]  hidx_reg;
    logic [15:0] rcv_reg;

    logic [15:0] len, pos;
    logic        bad;
    logic [31:0] w [6];
    logic [32:0] age_sum;
    logic        fbad;

    assign len = {win_reg[5], win_reg[4]};
    assign pos = held_reg - 16'(HDR_LEN);
    assign bad = (held_reg != 16'd0) && ((win_reg[0] != SYNC_A) ||
                 ((held_reg > 16'd1) && (win_reg[1] != SYNC_B)));
    assign age_sum = {1'b0, age_reg} + {1'b0, ela_reg};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w[i] = {cap_reg[i*4+3], cap_reg[i*4+2], cap_reg[i*4+1], cap_reg[i*4]};
        end
        fbad = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (w[i][30:23] == 8'hFF) fbad = 1'b1;
        end
        if (w[4][31]) begin
            if (w[4] != 32'h8000_0000) fbad = 1'b1;
        end else if (w[4] > 32'h3F80_0000) begin
            fbad = 1'b1;
        end
    end

    assign stat.scan_done = !bad;
    assign stat.hcrc_done = (hidx_reg == 3'd7);
    assign stat.need_check = chk_reg;
    assign stat.need_hcrc = !bad && !chk_reg && !hcrc_need_reg &&
                            (held_reg == 16'(HDR_LEN)) && (32'(len) <= 32'(MAX_PAYLOAD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) win_reg[i] <= 8'd0;
            held_reg <= '0;
            crc_reg <= CRC_INIT;
            crc_low_reg <= '0;
            for (int i = 0; i < 6; i++) fld_reg[i] <= '0;
            valid_reg <= 1'b0;
            track_reg <= 1'b0;
            upd_reg <= '0;
            age_reg <= '0;
            tmo_reg <= '0;
            code_reg <= 8'd1;
            st_reg <= ST_NONE;
            chk_reg <= 1'b0;
            hcrc_need_reg <= 1'b0;
            hidx_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TIMEOUT) tmo_reg <= cfg_data;
                else code_reg <= cfg_data[7:0];
            end
            if (cmd.load) begin
                byte_reg <= in_item.data_byte;
                ela_reg <= in_item.elapsed_ms;
                st_reg <= ST_NONE;
                chk_reg <= 1'b0;
                hcrc_need_reg <= 1'b0;
            end
            if (cmd.do_byte) begin
                if (held_reg < 16'(HDR_LEN)) begin
                    win_reg[held_reg[2:0]] <= byte_reg;
                    held_reg <= held_reg + 16'd1;
                end else if (pos < len) begin
                    if (pos < 16'(TGT_LEN)) cap_reg[pos[4:0]] <= byte_reg;
                    crc_reg <= crc_byte(crc_reg, byte_reg);
                    held_reg <= held_reg + 16'd1;
                end else if (pos == len) begin
                    crc_low_reg <= byte_reg;
                    held_reg <= held_reg + 16'd1;
                end else begin
                    rcv_reg <= {byte_reg, crc_low_reg};
                    chk_reg <= 1'b1;
                end
            end
            if (cmd.scan && !chk_reg) begin
                if (bad) begin
                    for (int i = 0; i < 7; i++) win_reg[i] <= win_reg[i+1];
                    held_reg <= held_reg - 16'd1;
                end else if (held_reg == 16'(HDR_LEN) && !hcrc_need_reg) begin
                    if (32'(len) > 32'(MAX_PAYLOAD)) begin
                        for (int i = 0; i < 7; i++) win_reg[i] <= win_reg[i+1];
                        held_reg <= held_reg - 16'd1;
                        st_reg <= ST_OVERSIZE;
                    end else begin
                        hcrc_need_reg <= 1'b1;
                        hidx_reg <= '0;
                        crc_reg <= CRC_INIT;
                    end
                end
            end
            if (cmd.hcrc) begin
                crc_reg <= crc_byte(crc_reg, win_reg[hidx_reg]);
                hidx_reg <= hidx_reg + 3'd1;
            end
            if (cmd.check) begin
                held_reg <= '0;
                crc_reg <= CRC_INIT;
                if (win_reg[2] != PROTO_VERSION || rcv_reg != crc_reg) begin
                    st_reg <= ST_INVALID;
                end else if (win_reg[3] != code_reg) begin
                    st_reg <= ST_OTHER;
                end else if (len != 16'(TGT_LEN) || fbad) begin
                    st_reg <= ST_INVALID;
                end else begin
                    for (int i = 0; i < 6; i++) fld_reg[i] <= w[i];
                    valid_reg <= (cap_reg[24] != 8'd0);
                    track_reg <= (cap_reg[24] != 8'd0);
                    upd_reg <= upd_reg + 32'd1;
                    age_reg <= '0;
                    st_reg <= ST_TARGET;
                end
            end
            if (cmd.tick) begin
                age_reg <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
                if (tmo_reg != 32'd0 &&
                    (age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0]) > tmo_reg) begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_item.status = st_reg;
    assign out_item.target_valid = valid_reg;
    assign out_item.tracking = track_reg;
    assign out_item.yaw_bits = fld_reg[0];
    assign out_item.pitch_bits = fld_reg[1];
    assign out_item.yaw_rate_bits = fld_reg[2];
    assign out_item.pitch_rate_bits = fld_reg[3];
    assign out_item.confidence_bits = fld_reg[4];
    assign out_item.stamp_ms = fld_reg[5];
    assign out_item.updates = upd_reg;
endmodule

[verif/tb.sv]
// Self-checking testbench for target_frame_receiver: frames, resyncs, ticks and timeouts.
// Depends on tfr_pkg and the target_frame_receiver RTL; predicts each result internally.
module tb
    import tfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP = 64;

    class frame_scoreboard;
        logic [7:0]  hdr [8];
        int unsigned held;
        logic [15:0] crc;
        logic [7:0]  crc_lo;
        logic [7:0]  cap [25];
        logic [31:0] words [6];
        logic        tvalid, ttrack;
        logic [31:0] upd, age, timeout;
        logic [7:0]  code;
        tfr_out_t    pending [$];
        int          errors, checked;
        int          n_status [5];

        function new();
            foreach (hdr[i]) hdr[i] = 0;
            foreach (cap[i]) cap[i] = 0;
            foreach (words[i]) words[i] = 0;
            held = 0; crc = CRC_INIT; crc_lo = 0;
            tvalid = 0; ttrack = 0; upd = 0; age = 0; timeout = 0; code = 8'd1;
            errors = 0; checked = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            c = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void shift_out();
            if (held == 0) return;
            for (int i = 1; i < held && i < 8; i++) hdr[i-1] = hdr[i];
            held--;
        endfunction

        function logic [2:0] close_frame(int unsigned len, logic [15:0] rx);
            logic [31:0] w [6];
            if (hdr[2] != PROTO_VERSION || rx != crc) return ST_INVALID;
            if (hdr[3] != code) return ST_OTHER;
            if (len != TGT_LEN) return ST_INVALID;
            for (int i = 0; i < 6; i++)
                w[i] = {cap[4*i+3], cap[4*i+2], cap[4*i+1], cap[4*i]};
            for (int i = 0; i < 5; i++)
                if (w[i][30:23] == 8'hFF) return ST_INVALID;
            if (w[4][31]) begin
                if (w[4] != 32'h8000_0000) return ST_INVALID;
            end else if (w[4] > 32'h3F80_0000) return ST_INVALID;
            words = w;
            tvalid = cap[24] != 0; ttrack = cap[24] != 0;
            upd++; age = 0;
            return ST_TARGET;
        endfunction

        function logic [2:0] take_byte(logic [7:0] b);
            int unsigned len, pos;
            logic [2:0] st;
            st = ST_NONE;
            if (held < 8) begin
                hdr[held] = b; held++;
                while (held > 0 && (hdr[0] != SYNC_A || (held > 1 && hdr[1] != SYNC_B)))
                    shift_out();
                if (held == 8) begin
                    len = {hdr[5], hdr[4]};
                    if (len > MAXP) begin
                        shift_out(); st = ST_OVERSIZE;
                    end else begin
                        crc = CRC_INIT;
                        for (int i = 0; i < 8; i++) crc = crc_step(crc, hdr[i]);
                    end
                end
                return st;
            end
            len = {hdr[5], hdr[4]};
            pos = held - 8;
            if (pos < len) begin
                if (pos < 25) cap[pos] = b;
                crc = crc_step(crc, b); held++;
            end else if (pos == len) begin
                crc_lo = b; held++;
            end else begin
                st = close_frame(len, {b, crc_lo});
                held = 0; crc = CRC_INIT;
            end
            return st;
        endfunction

        function void note_input(tfr_in_t it);
            tfr_out_t r;
            r.status = ST_NONE;
            if (it.opcode == OP_BYTE) r.status = take_byte(it.data_byte);
            else begin
                if (age > 32'hFFFF_FFFF - it.elapsed_ms) age = 32'hFFFF_FFFF;
                else age += it.elapsed_ms;
                if (timeout != 0 && age > timeout) tvalid = 0;
            end
            r.target_valid = tvalid; r.tracking = ttrack;
            r.yaw_bits = words[0]; r.pitch_bits = words[1];
            r.yaw_rate_bits = words[2]; r.pitch_rate_bits = words[3];
            r.confidence_bits = words[4]; r.stamp_ms = words[5];
            r.updates = upd;
            pending.push_back(r);
        endfunction

        function void check_result(tfr_out_t got);
            tfr_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.status <= ST_OVERSIZE) n_status[e.status]++;
            if (got !== e) begin
                errors++;
                $display("%0t: mismatch expected %h actual %h", $time, e, got);
                if (got.status !== e.status)
                    $display("  status expected %0d actual %0d", e.status, got.status);
            end
        endfunction
    endclass

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready, cfg_we;
    tfr_in_t s_item;
    tfr_out_t m_item;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;

    frame_scoreboard sb;
    int send_idle, recv_stall, hold_cycles, sent;

    target_frame_receiver #(.MAX_PAYLOAD(MAXP)) dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else m_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(tfr_in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        sent++;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b);
        tfr_in_t it;
        it.opcode = OP_BYTE; it.data_byte = b; it.elapsed_ms = $urandom;
        send_item(it);
    endtask

    task automatic send_tick(logic [31:0] ms);
        tfr_in_t it;
        it.opcode = OP_TICK; it.data_byte = $urandom; it.elapsed_ms = ms;
        send_item(it);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TIMEOUT) sb.timeout = val;
        else sb.code = val[7:0];
    endtask

    // kind: 0 good target, 1 bad float, 2 bad confidence, 3 other type,
    // 4 bad crc, 5 bad version, 6 wrong target length
    task automatic send_frame(int kind, logic [31:0] conf, logic [7:0] trk);
        logic [7:0] f [$];
        logic [15:0] c;
        logic [31:0] w;
        int unsigned len;
        len = (kind == 3) ? $urandom_range(0, MAXP) : (kind == 6 ? $urandom_range(0, 30) : 25);
        if (kind == 6 && len == 25) len = 24;
        f = {SYNC_A, SYNC_B, (kind == 5) ? 8'd2 : PROTO_VERSION,
             (kind == 3) ? sb.code + 8'd1 + 8'($urandom_range(0, 250)) : sb.code,
             len[7:0], len[15:8], 8'($urandom), 8'($urandom)};
        for (int i = 0; i < 5; i++) begin
            w = $urandom;
            w[30:23] = $urandom_range(0, 254);
            if (kind == 1 && i == 2) w[30:23] = 8'hFF;
            if (i == 4) w = (kind == 2) ? 32'h3F80_0001 : conf;
            for (int j = 0; j < 4; j++) if (4*i+j < len) f.push_back(w[8*j +: 8]);
        end
        w = $urandom;
        for (int j = 0; j < 4; j++) if (20+j < len) f.push_back(w[8*j +: 8]);
        if (len > 24) f.push_back(trk);
        while (f.size() < len + 8) f.push_back($urandom);
        c = CRC_INIT;
        foreach (f[i]) c = sb.crc_step(c, f[i]);
        if (kind == 4) c ^= 16'h0001 << $urandom_range(0, 15);
        f.push_back(c[7:0]); f.push_back(c[15:8]);
        foreach (f[i]) send_byte(f[i]);
    endtask

    task automatic random_phase(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 55) send_frame($urandom_range(0, 6) == 0 ? $urandom_range(1, 6) : 0,
                                   $urandom_range(0, 32'h3F80_0000), $urandom_range(0, 3) == 0 ?
                                   8'd0 : 8'($urandom));
            else if (r < 70) send_tick($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500));
            else if (r < 80) send_byte($urandom_range(0, 1) ? SYNC_A : 8'($urandom));
            else if (r < 90) begin
                send_byte(SYNC_A); send_byte(SYNC_B);
                repeat (6) send_byte($urandom);
            end else send_frame(3, 0, 0);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 0; s_valid = 0; s_item = '0; m_ready = 0;
        cfg_we = 0; cfg_index = REG_TIMEOUT; cfg_data = 0;
        send_idle = 0; recv_stall = 0; hold_cycles = 0; sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, resync, oversize, each error class, timeout.
        send_tick(32'hFFFF_FFFF);
        send_frame(0, 32'h3F80_0000, 8'hFF);
        send_frame(0, 32'h8000_0000, 8'h00);
        send_frame(0, 32'h0000_0000, 8'h01);
        send_byte(SYNC_A); send_byte(SYNC_A); send_byte(SYNC_B);
        send_byte(8'd1); send_byte(8'd1); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h00);
        for (int k = 1; k <= 6; k++) send_frame(k, 0, 0);
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT, 32'd100);
        send_frame(0, 32'h3F00_0000, 8'h01);
        send_tick(32'd100);
        send_tick(32'd1);
        write_reg(REG_CODE, 8'hFF);
        send_frame(0, 32'h3F00_0000, 8'h01);
        send_frame(3, 0, 0);

        send_idle = 0; recv_stall = 0;
        random_phase(4);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_CODE, 8'h00);
        send_idle = 49; random_phase(4);
        write_reg(REG_TIMEOUT, $urandom_range(50, 2000));
        write_reg(REG_CODE, $urandom);
        send_idle = 0; recv_stall = 49; random_phase(4);
        hold_cycles = 400;
        random_phase(2);
        drain();
        write_reg(REG_TIMEOUT, 32'd0);
        write_reg(REG_CODE, 8'd1);
        send_idle = 29; recv_stall = 29; random_phase(4);

        drain();
        $display("Checked %0d results over %0d items: other %0d, target %0d,",
                 sb.checked, sent, sb.n_status[1], sb.n_status[2]);
        $display("invalid %0d, oversize %0d, across idle, stall and long hold phases.",
                 sb.n_status[3], sb.n_status[4]);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
